@@ hdl/fmnrw_pkg.sv @@
// Package for the FM note register writer: payload structs, event codes,
// register address bases and the note to frequency-number helpers.
// Depends on nothing; used by fm_note_register_writer_top.
`default_nettype none

package fmnrw_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MAX_WRITES = 6;
    localparam int unsigned WR_IDX_W   = 3;
    localparam int unsigned NUM_CHAN   = 9;
    localparam int unsigned NUM_VOICE  = 11;

    // Event codes
    localparam logic [1:0] ACT_NOTE   = 2'd0;
    localparam logic [1:0] ACT_VOLUME = 2'd1;
    localparam logic [1:0] ACT_KSL    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_RHYTHM = 1'b0;

    // OPL2 register bases
    localparam logic [7:0] REG_FNUM_LO = 8'hA0;
    localparam logic [7:0] REG_KEY_BLK = 8'hB0;
    localparam logic [7:0] REG_LEVEL   = 8'h40;
    localparam logic [7:0] REG_RHYTHM  = 8'hBD;
    localparam logic [7:0] RHYTHM_EN   = 8'h20;
    localparam logic [7:0] KEY_ON      = 8'h20;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] voice;
        logic [6:0] note;
        logic       silence;
        logic [5:0] volume;
        logic [1:0] key_scale;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] lo;   // low eight fnum bits
        logic [4:0] hi;   // block and top two fnum bits
    } t_freq;

    function automatic logic [9:0] fnum_of(input logic [3:0] semi);
        logic [9:0] f;
        case (semi)
            4'd0:    f = 10'd340;
            4'd1:    f = 10'd363;
            4'd2:    f = 10'd385;
            4'd3:    f = 10'd408;
            4'd4:    f = 10'd432;
            4'd5:    f = 10'd458;
            4'd6:    f = 10'd485;
            4'd7:    f = 10'd514;
            4'd8:    f = 10'd544;
            4'd9:    f = 10'd577;
            4'd10:   f = 10'd611;
            4'd11:   f = 10'd647;
            default: f = 10'd340;
        endcase
        return f;
    endfunction

    // Split a note (0..134) into octave and semitone: multiply by 171/2048,
    // exact for this range.
    function automatic t_freq freq_of(input logic [7:0] note);
        logic [14:0] prod;
        logic [3:0]  oct;
        logic [7:0]  rem8;
        logic [9:0]  fnum;
        t_freq       res;
        prod = 15'(note) * 15'd171;
        oct  = prod[14:11];
        rem8 = note - (8'(oct) * 8'd12);
        fnum = fnum_of(rem8[3:0]);
        res.lo = fnum[7:0];
        res.hi = {oct[2:0], fnum[9:8]};
        return res;
    endfunction

    function automatic logic [7:0] carrier_off(input logic [3:0] v);
        logic [7:0] o;
        case (v)
            4'd0:    o = 8'h03;
            4'd1:    o = 8'h04;
            4'd2:    o = 8'h05;
            4'd3:    o = 8'h0B;
            4'd4:    o = 8'h0C;
            4'd5:    o = 8'h0D;
            4'd6:    o = 8'h13;
            4'd7:    o = 8'h14;
            default: o = 8'h15;
        endcase
        return o;
    endfunction

    function automatic logic [7:0] drum_off(input logic [1:0] d);
        logic [7:0] o;
        case (d)
            2'd0:    o = 8'h14;
            2'd1:    o = 8'h12;
            2'd2:    o = 8'h15;
            default: o = 8'h11;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fm_note_register_writer_top.sv @@
// Top level of the FM note register writer: input register, event decode,
// write list buffer and configuration port.
// Depends on fmnrw_pkg.
`default_nettype none

// Turns note, volume and key-scale events for up to eleven voices into OPL2
// register writes. Each event is held in an input register; when the write
// buffer is free it is decoded combinationally into its full list of one to
// six writes (address, data, last) and the voice caches are updated. The list
// then leaves one write per cycle through the single output port while
// i_out_stall is low, and the next event is taken into the input register
// while the current list drains. Events that cause no write (unknown action,
// voice out of range) pass through the input register and do not enter the
// write buffer. The sole configuration register, rhythm_mode at byte address
// 0 (reset 1), selects percussion on voices 6 to 10; write it only while no
// event is in flight. Drum key bits and the frequency and level caches are
// kept across mode changes.
module fm_note_register_writer_top
    import fmnrw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // event channel
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire t_in_item              i_in,
    // register write channel
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      t_out_item             o_out,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output      logic [CFG_DATA_W-1:0] prdata,
    output      logic                  pready
);

    // Configuration and voice state
    logic       r_rhythm;
    logic [4:0] r_drum_bits;
    logic [4:0] r_freq_high [NUM_CHAN];
    logic [7:0] r_level     [NUM_VOICE];

    // Input register
    logic     r_in_valid;
    t_in_item r_in;

    // Write list buffer
    logic                r_buf_valid;
    logic [WR_IDX_W-1:0] r_idx;
    logic [WR_IDX_W-1:0] r_cnt;
    logic [7:0]          r_addr [MAX_WRITES];
    logic [7:0]          r_data [MAX_WRITES];

    // Decode results
    logic [7:0]          n_addr [MAX_WRITES];
    logic [7:0]          n_data [MAX_WRITES];
    logic [WR_IDX_W-1:0] n_cnt;
    logic [4:0]          n_drum_bits;
    logic                w_wr_fh7;
    logic                w_wr_fh_v;
    logic [3:0]          w_fh_idx;
    logic [4:0]          n_fh7;
    logic [4:0]          n_fh_v;
    logic                w_wr_level;
    logic [7:0]          n_level;

    logic w_out_xfer;
    logic w_is_last;
    logic w_buf_free;
    logic w_load;
    logic w_in_xfer;
    logic w_cfg_wr;

    // ---------------------------------------------------------------
    // Handshakes: the input register frees as soon as its event moves
    // into the buffer, which happens when the buffer is empty or on the
    // cycle the last write of the previous list is transferred.
    // ---------------------------------------------------------------
    assign w_out_xfer = r_buf_valid && !i_out_stall;
    assign w_is_last  = (r_idx == (r_cnt - WR_IDX_W'(1)));
    assign w_buf_free = !r_buf_valid || (w_out_xfer && w_is_last);
    assign w_load     = r_in_valid && w_buf_free;
    assign o_in_stall = r_in_valid && !w_load;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    assign o_out_valid    = r_buf_valid;
    assign o_out.reg_addr = r_addr[r_idx];
    assign o_out.reg_data = r_data[r_idx];
    assign o_out.last     = w_is_last;

    // ---------------------------------------------------------------
    // Configuration port: writes land in the access phase, reads return
    // the mode bit, anything above register 0 reads as zero.
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == CFG_RHYTHM) ? {{(CFG_DATA_W-1){1'b0}}, r_rhythm}
                                               : '0;

    // ---------------------------------------------------------------
    // Event decode: build the whole write list for the held event from
    // the current caches.
    // ---------------------------------------------------------------
    always_comb begin
        logic [3:0] v;
        logic       drum;
        logic       in_range;
        logic [4:0] bit_mask;
        logic [4:0] drum_clr;
        logic [4:0] drum_set;
        logic [7:0] v8;
        t_freq      f_note;
        t_freq      f_snare;

        v        = r_in.voice;
        v8       = {4'd0, v};
        drum     = r_rhythm && (v >= 4'd6);
        in_range = (v <= 4'd10) && (r_rhythm || (v <= 4'd8));
        bit_mask = 5'd1 << (4'd10 - v);
        drum_clr = r_drum_bits & ~bit_mask;
        drum_set = drum_clr | bit_mask;
        f_note   = freq_of({1'b0, r_in.note});
        f_snare  = freq_of({1'b0, r_in.note} + 8'd7);

        for (int k = 0; k < MAX_WRITES; k++) begin
            n_addr[k] = REG_RHYTHM;
            n_data[k] = {3'd0, drum_set} | RHYTHM_EN;
        end
        n_cnt       = '0;
        n_drum_bits = r_drum_bits;
        w_wr_fh7    = 1'b0;
        w_wr_fh_v   = 1'b0;
        w_fh_idx    = v;
        n_fh7       = f_snare.hi;
        n_fh_v      = f_note.hi;
        w_wr_level  = 1'b0;
        n_level     = r_level[v];

        if (in_range) begin
            case (r_in.action)
                ACT_NOTE: begin
                    if (drum) begin
                        n_addr[0]   = REG_RHYTHM;
                        n_data[0]   = {3'd0, drum_clr} | RHYTHM_EN;
                        n_drum_bits = drum_clr;
                        n_cnt       = WR_IDX_W'(1);
                        if (!r_in.silence) begin
                            n_drum_bits = drum_set;
                            if (v == 4'd8) begin
                                // tom: retune the snare channel first
                                n_addr[1] = REG_FNUM_LO + 8'd7;
                                n_data[1] = f_snare.lo;
                                n_addr[2] = REG_KEY_BLK + 8'd7;
                                n_data[2] = {3'd0, f_snare.hi};
                                n_addr[3] = REG_FNUM_LO + v8;
                                n_data[3] = f_note.lo;
                                n_addr[4] = REG_KEY_BLK + v8;
                                n_data[4] = {3'd0, f_note.hi};
                                w_wr_fh7  = 1'b1;
                                w_wr_fh_v = 1'b1;
                                n_cnt     = WR_IDX_W'(6);
                            end else if (v == 4'd6) begin
                                n_addr[1] = REG_FNUM_LO + v8;
                                n_data[1] = f_note.lo;
                                n_addr[2] = REG_KEY_BLK + v8;
                                n_data[2] = {3'd0, f_note.hi};
                                w_wr_fh_v = 1'b1;
                                n_cnt     = WR_IDX_W'(4);
                            end else begin
                                n_cnt = WR_IDX_W'(2);
                            end
                        end
                    end else begin
                        // melodic: key off with the cached block, then retune
                        n_addr[0] = REG_KEY_BLK + v8;
                        n_data[0] = {3'd0, r_freq_high[v]};
                        n_cnt     = WR_IDX_W'(1);
                        if (!r_in.silence) begin
                            n_addr[1] = REG_FNUM_LO + v8;
                            n_data[1] = f_note.lo;
                            n_addr[2] = REG_KEY_BLK + v8;
                            n_data[2] = {3'd0, f_note.hi} | KEY_ON;
                            w_wr_fh_v = 1'b1;
                            n_cnt     = WR_IDX_W'(3);
                        end
                    end
                end
                ACT_VOLUME, ACT_KSL: begin
                    if (r_in.action == ACT_VOLUME) begin
                        n_level = {r_level[v][7:6], r_in.volume};
                    end else begin
                        n_level = {r_in.key_scale, r_level[v][5:0]};
                    end
                    w_wr_level = 1'b1;
                    if ((v < 4'd7) || !r_rhythm) begin
                        n_addr[0] = REG_LEVEL + carrier_off(v);
                    end else begin
                        n_addr[0] = REG_LEVEL + drum_off(2'(v - 4'd7));
                    end
                    n_data[0] = n_level;
                    n_cnt     = WR_IDX_W'(1);
                end
                default: begin
                    n_cnt = '0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control and voice state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rhythm    <= 1'b1;
            r_drum_bits <= '0;
            r_in_valid  <= 1'b0;
            r_buf_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_freq_high[k] <= '0;
            end
            for (int k = 0; k < NUM_VOICE; k++) begin
                r_level[k] <= '0;
            end
        end else begin
            if (w_cfg_wr && (paddr[2] == CFG_RHYTHM)) begin
                r_rhythm <= pwdata[0];
            end

            // hold the input register until its event moves on
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end

            if (w_load) begin
                r_buf_valid <= (n_cnt != '0);
                r_cnt       <= n_cnt;
                r_idx       <= '0;
                r_drum_bits <= n_drum_bits;
                if (w_wr_fh7) begin
                    r_freq_high[7] <= n_fh7;
                end
                if (w_wr_fh_v) begin
                    r_freq_high[w_fh_idx] <= n_fh_v;
                end
                if (w_wr_level) begin
                    r_level[r_in.voice] <= n_level;
                end
            end else if (w_out_xfer) begin
                // advance to the next write of the list
                r_idx <= r_idx + WR_IDX_W'(1);
                if (w_is_last) begin
                    r_buf_valid <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in;
        end
        if (w_load) begin
            for (int k = 0; k < MAX_WRITES; k++) begin
                r_addr[k] <= n_addr[k];
                r_data[k] <= n_data[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_idx_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_valid |-> (r_idx < r_cnt))
        else $error("write index beyond list length");

    a_rhythm_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.reg_addr == REG_RHYTHM)) |-> o_out.reg_data[5])
        else $error("rhythm register written without rhythm enable");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_buf_valid))
        else $error("input stalled with free buffer");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("channels busy after reset");

endmodule

`default_nettype wire

@@ tb/sv/tb_fm_note_register_writer_top.sv @@
// Self-checking testbench for fm_note_register_writer_top: a directed table, then
// random events under several idling patterns, checked against a local predictor.
// Depends on fmnrw_pkg and fm_note_register_writer_top.
module tb_fm_note_register_writer_top;
    import fmnrw_pkg::*;

    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] RHYTHM_ADDR = CFG_ADDR_W'(4 * CFG_RHYTHM);

    // Frequency numbers per semitone, entry 0 in the low ten bits
    localparam logic [119:0] FNUM_LIST = {
        10'd647, 10'd611, 10'd577, 10'd544, 10'd514, 10'd485,
        10'd458, 10'd432, 10'd408, 10'd385, 10'd363, 10'd340
    };
    // Carrier operator offsets for channels 0..8, and drum operator offsets
    // for snare, tom, cymbal and hi-hat
    localparam logic [71:0] CARRIER_LIST = {
        8'h15, 8'h14, 8'h13, 8'h0D, 8'h0C, 8'h0B, 8'h05, 8'h04, 8'h03
    };
    localparam logic [31:0] DRUM_LIST = {8'h11, 8'h15, 8'h12, 8'h14};

    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 400_000;
    localparam int PHASE_EVENTS   = 57;
    localparam int NUM_PHASES     = 8;

    typedef enum logic {ROW_EVENT, ROW_MODE} t_row_kind;

    // One stimulus row: an event, or a rhythm mode change. Where n_typed is
    // not negative, the first n_typed entries of typed are the writes expected.
    typedef struct packed {
        t_row_kind          kind;
        logic               mode_val;
        t_in_item           ev;
        int                 n_typed;
        t_out_item [2:0]    typed;
    } t_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in       = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    fm_note_register_writer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted state of the block
    logic       rhythm_on;
    logic [4:0] drum_keys;
    logic [4:0] freq_hi [0:8];
    logic [7:0] level_byte [0:10];

    // Writes caused by the event being decoded, and writes still to arrive
    t_out_item  ev_writes [0:5];
    int         ev_count;
    t_out_item  due_writes [$];

    int idle_pct;
    int stall_pct;
    int fail_count;
    int cycle_count;
    int events_sent;
    int events_ignored;
    int writes_seen;
    int mode_writes;
    t_row plan [$];

    // Append to the stimulus plan and to the list of writes still to arrive
    function automatic void queue_row(input t_row r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic void queue_write(input t_out_item w);
        due_writes.insert(due_writes.size(), w);
    endfunction

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void add_write(input logic [7:0] addr, input logic [7:0] data);
        ev_writes[ev_count] = '{reg_addr: addr, reg_data: data, last: 1'b0};
        ev_count++;
    endfunction

    // Load fnum low byte, then block and high fnum bits, of one channel
    function automatic void add_freq(input logic [3:0] ch, input logic [7:0] nt,
                                     input logic key_on);
        logic [3:0]  semi;
        logic [2:0]  blk;
        logic [12:0] freq;
        semi = 4'(nt % 12);
        blk  = 3'(nt / 12);    // octave wraps at three bits
        freq = {blk, FNUM_LIST[semi * 10 +: 10]};
        freq_hi[ch] = freq[12:8];
        add_write(REG_FNUM_LO + ch, freq[7:0]);
        add_write(REG_KEY_BLK + ch, {3'b000, freq[12:8]} | (key_on ? KEY_ON : 8'h00));
    endfunction

    // Work out the writes of one event into ev_writes and return their number
    function automatic int decode_event(input t_in_item ev);
        logic [3:0] v;
        logic [4:0] key_bit;
        logic [7:0] lvl_addr;
        logic [1:0] drum_idx;
        v = ev.voice;
        ev_count = 0;
        if (v > 4'd10 || (!rhythm_on && v > 4'd8) || ev.action == ACT_UNUSED)
            return 0;
        if (ev.action == ACT_NOTE) begin
            if (rhythm_on && v >= 4'd6) begin
                key_bit   = 5'd1 << (4'd10 - v);
                drum_keys = drum_keys & ~key_bit;
                add_write(REG_RHYTHM, {3'b000, drum_keys} | RHYTHM_EN);
                if (!ev.silence) begin
                    // the tom retunes the snare channel a fifth up
                    if (v == 4'd8)
                        add_freq(4'd7, {1'b0, ev.note} + 8'd7, 1'b0);
                    if (v == 4'd8 || v == 4'd6)
                        add_freq(v, {1'b0, ev.note}, 1'b0);
                    drum_keys = drum_keys | key_bit;
                    add_write(REG_RHYTHM, {3'b000, drum_keys} | RHYTHM_EN);
                end
            end else begin
                add_write(REG_KEY_BLK + v, {3'b000, freq_hi[v]});
                if (!ev.silence)
                    add_freq(v, {1'b0, ev.note}, 1'b1);
            end
        end else begin
            if (ev.action == ACT_VOLUME)
                level_byte[v][5:0] = ev.volume;
            else
                level_byte[v][7:6] = ev.key_scale;
            if (v < 4'd7 || !rhythm_on) begin
                lvl_addr = REG_LEVEL + CARRIER_LIST[v * 8 +: 8];
            end else begin
                drum_idx = 2'(v - 4'd7);
                lvl_addr = REG_LEVEL + DRUM_LIST[drum_idx * 8 +: 8];
            end
            add_write(lvl_addr, level_byte[v]);
        end
        return ev_count;
    endfunction

    // ---------------------------------------------------------------
    // Table helpers
    // ---------------------------------------------------------------
    function automatic t_in_item mk_event(input logic [1:0] a, input logic [3:0] v,
                                          input logic [6:0] nt, input logic s,
                                          input logic [5:0] vol, input logic [1:0] ks);
        return '{action: a, voice: v, note: nt, silence: s, volume: vol, key_scale: ks};
    endfunction

    function automatic t_out_item wr(input logic [7:0] a, input logic [7:0] d,
                                     input logic l);
        return '{reg_addr: a, reg_data: d, last: l};
    endfunction

    function automatic void plan_event(input t_in_item ev, input int n,
                                       input t_out_item w0, input t_out_item w1,
                                       input t_out_item w2);
        t_row r;
        r.kind     = ROW_EVENT;
        r.mode_val = 1'b0;
        r.ev       = ev;
        r.n_typed  = n;
        r.typed    = {w2, w1, w0};
        queue_row(r);
    endfunction

    function automatic void plan_mode(input logic val);
        t_row r;
        r          = '0;
        r.kind     = ROW_MODE;
        r.mode_val = val;
        queue_row(r);
    endfunction

    // Mostly well-formed events on live voices; the rest is noise the block drops
    function automatic t_in_item random_event();
        t_in_item ev;
        int       pick;
        pick         = $urandom_range(0, 99);
        ev.note      = 7'($urandom_range(0, 127));
        ev.silence   = ($urandom_range(0, 3) == 0);
        ev.volume    = 6'($urandom_range(0, 63));
        ev.key_scale = 2'($urandom_range(0, 3));
        if (pick < 6) begin
            ev.action = ACT_UNUSED;
            ev.voice  = 4'($urandom_range(0, 15));
        end else if (pick < 12) begin
            ev.action = 2'($urandom_range(0, 2));
            ev.voice  = 4'($urandom_range(rhythm_on ? 11 : 9, 15));
        end else begin
            ev.action = (pick < 60) ? ACT_NOTE : 2'($urandom_range(1, 2));
            ev.voice  = 4'($urandom_range(0, rhythm_on ? 10 : 8));
        end
        return ev;
    endfunction

    // ---------------------------------------------------------------
    // Event channel
    // ---------------------------------------------------------------
    // Offer one event, hold it until the transfer, then queue its writes.
    // Returns at the transfer edge so the caller drives the next value there.
    task automatic send_event(input t_row r, output int n_writes);
        t_out_item w;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r.ev;
        do @(posedge i_clk); while (o_in_stall);
        n_writes = decode_event(r.ev);
        if (r.n_typed >= 0) begin
            for (int i = 0; i < r.n_typed; i++)
                queue_write(r.typed[i]);
        end else begin
            for (int i = 0; i < n_writes; i++) begin
                w      = ev_writes[i];
                w.last = (i == n_writes - 1);
                queue_write(w);
            end
        end
        events_sent++;
        if (n_writes == 0)
            events_ignored++;
    endtask

    // Drop valid and hold off until every queued write has come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (due_writes.size() != 0)
            @(posedge i_clk);
        // let a dropped event clear the input register
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    // Setup and access phase, then the bus goes idle before the next transfer
    task automatic apb_transfer(input logic wr_en, input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr_en;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Change rhythm mode only with nothing in flight, then read it back
    task automatic set_rhythm(input logic val);
        logic [CFG_DATA_W-1:0] rd;
        wait_idle();
        apb_transfer(1'b1, RHYTHM_ADDR, CFG_DATA_W'(val), rd);
        rhythm_on = val;
        apb_transfer(1'b0, RHYTHM_ADDR, '0, rd);
        if (rd !== CFG_DATA_W'(val)) begin
            $error("rhythm_mode readback: expected %0h, actual %0h", val, rd);
            fail_count++;
        end
        mode_writes++;
    endtask

    // ---------------------------------------------------------------
    // Register write channel: random stall and checking
    // ---------------------------------------------------------------
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge i_clk) begin : check_writes
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_writes.size() == 0) begin
                $error("unexpected register write: addr %h data %h last %b",
                       o_out.reg_addr, o_out.reg_data, o_out.last);
                fail_count++;
            end else begin
                want = due_writes.pop_front();
                if (o_out.reg_addr !== want.reg_addr) begin
                    $error("reg_addr: expected %h, actual %h", want.reg_addr, o_out.reg_addr);
                    fail_count++;
                end
                if (o_out.reg_data !== want.reg_data) begin
                    $error("reg_data: expected %h, actual %h", want.reg_data, o_out.reg_data);
                    fail_count++;
                end
                if (o_out.last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_out.last);
                    fail_count++;
                end
                writes_seen++;
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                     cycle_count, due_writes.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int n_writes;
        t_row r;

        idle_pct       = 0;
        stall_pct      = 0;
        fail_count     = 0;
        cycle_count    = 0;
        events_sent    = 0;
        events_ignored = 0;
        writes_seen    = 0;
        mode_writes    = 0;
        rhythm_on      = 1'b1;
        drum_keys      = '0;
        foreach (freq_hi[i])
            freq_hi[i] = '0;
        foreach (level_byte[i])
            level_byte[i] = '0;

        // Directed table; rhythm mode is on out of reset
        plan_mode(1'b1);
        // level extremes on carrier and drum operators
        plan_event(mk_event(ACT_VOLUME, 0, 0, 0, 63, 0), 1, wr(8'h43, 8'h3F, 1), '0, '0);
        plan_event(mk_event(ACT_KSL, 0, 0, 0, 0, 3), 1, wr(8'h43, 8'hFF, 1), '0, '0);
        plan_event(mk_event(ACT_KSL, 10, 0, 0, 0, 3), 1, wr(8'h51, 8'hC0, 1), '0, '0);
        plan_event(mk_event(ACT_VOLUME, 7, 0, 0, 0, 0), 1, wr(8'h54, 8'h00, 1), '0, '0);
        // dropped: unknown action, voice out of range
        plan_event(mk_event(ACT_UNUSED, 0, 0, 0, 0, 0), 0, '0, '0, '0);
        plan_event(mk_event(ACT_NOTE, 11, 0, 0, 0, 0), 0, '0, '0, '0);
        plan_event(mk_event(ACT_VOLUME, 15, 127, 1, 63, 3), 0, '0, '0, '0);
        // melodic key on from cold, then key off only
        plan_event(mk_event(ACT_NOTE, 0, 0, 0, 0, 0), 3,
                   wr(8'hB0, 8'h00, 0), wr(8'hA0, 8'h54, 0), wr(8'hB0, 8'h21, 1));
        plan_event(mk_event(ACT_NOTE, 0, 0, 1, 0, 0), 1, wr(8'hB0, 8'h01, 1), '0, '0);
        // octave wrap, then every drum
        plan_event(mk_event(ACT_NOTE, 5, 127, 0, 0, 0), -1, '0, '0, '0);
        plan_event(mk_event(ACT_NOTE, 6, 95, 0, 0, 0), -1, '0, '0, '0);
        plan_event(mk_event(ACT_NOTE, 8, 127, 0, 0, 0), -1, '0, '0, '0);
        plan_event(mk_event(ACT_NOTE, 7, 40, 0, 0, 0), -1, '0, '0, '0);
        plan_event(mk_event(ACT_NOTE, 9, 12, 1, 0, 0), -1, '0, '0, '0);
        plan_event(mk_event(ACT_NOTE, 10, 1, 0, 0, 0), -1, '0, '0, '0);
        plan_event(mk_event(ACT_VOLUME, 8, 0, 0, 63, 0), 1, wr(8'h52, 8'h3F, 1), '0, '0);
        plan_event(mk_event(ACT_VOLUME, 6, 0, 0, 21, 0), -1, '0, '0, '0);
        // all voices melodic
        plan_mode(1'b0);
        plan_event(mk_event(ACT_NOTE, 9, 30, 0, 0, 0), 0, '0, '0, '0);
        plan_event(mk_event(ACT_KSL, 10, 0, 0, 0, 2), 0, '0, '0, '0);
        plan_event(mk_event(ACT_NOTE, 8, 60, 0, 0, 0), -1, '0, '0, '0);
        plan_event(mk_event(ACT_VOLUME, 8, 0, 0, 1, 0), 1, wr(8'h55, 8'h01, 1), '0, '0);
        plan_event(mk_event(ACT_KSL, 7, 0, 0, 0, 2), 1, wr(8'h54, 8'h80, 1), '0, '0);
        plan_event(mk_event(ACT_NOTE, 7, 0, 1, 0, 0), -1, '0, '0, '0);
        // back to percussion: drum keys kept across the change
        plan_mode(1'b1);
        plan_event(mk_event(ACT_NOTE, 6, 0, 1, 0, 0), -1, '0, '0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            r = plan[i];
            if (r.kind == ROW_MODE)
                set_rhythm(r.mode_val);
            else
                send_event(r, n_writes);
        end

        // Random phases: alternate the mode, cycle the idling patterns
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_rhythm(phase[0]);
            case (phase % 4)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    idle_pct = 82; stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;  stall_pct = 82;
                end
                default: begin
                    idle_pct = 11; stall_pct = 11;
                end
            endcase
            for (int k = 0; k < PHASE_EVENTS; k++) begin
                r         = '0;
                r.kind    = ROW_EVENT;
                r.ev      = random_event();
                r.n_typed = -1;
                send_event(r, n_writes);
            end
        end

        wait_idle();
        $display("Ran %0d events (%0d dropped) and checked %0d register writes",
                 events_sent, events_ignored, writes_seen);
        $display("across %0d rhythm mode settings and four idling patterns", mode_writes);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
